// ----- design/lpcp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared types and constants of the line pair common perpendicular core.
// ----------------------------------------------------------------------------
package lpcp_pkg;

	// Multiplier operand B is consumed one limb of this many bits per stage
	localparam int LIMB = 16;

	// Result status carried on the output tuser
	typedef enum logic [1:0] {
		STAT_SOLVED = 2'd0,
		STAT_SHARED = 2'd1,
		STAT_NONE   = 2'd2
	} stat_t;

endpackage

// ----- design/lpcp_mul.sv -----
// ----------------------------------------------------------------------------
// lpcp_mul
// Pipelined signed multiplier: B is split into LIMB-bit limbs, one partial
// product is accumulated per stage.
// ----------------------------------------------------------------------------
module lpcp_mul
	import lpcp_pkg::*;
#(
	parameter int A_BITS = 33,
	parameter int B_BITS = 33,
	localparam int P_BITS = A_BITS + B_BITS
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [A_BITS-1:0] a,
	input  logic signed [B_BITS-1:0] b,
	output logic signed [P_BITS-1:0] p
);

	localparam int NL = (B_BITS + LIMB - 1) / LIMB;
	localparam int BX = NL * LIMB;
	localparam int PRW = A_BITS + LIMB + 1;

	logic signed [BX-1:0] b_ext;
	logic [A_BITS-1:0]    a_s   [NL];
	logic [BX-1:0]        b_s   [NL];
	logic [P_BITS-1:0]    acc_s [NL];

	assign b_ext = BX'(b);

	genvar k;
	generate
		for (k = 0; k < NL; k++) begin : g_stage
			logic [A_BITS-1:0]     a_src;
			logic [BX-1:0]         b_src;
			logic [P_BITS-1:0]     acc_in;
			logic [LIMB-1:0]       limb;
			logic signed [LIMB:0]  limb_x;
			logic signed [PRW-1:0] prod;
			logic [P_BITS-1:0]     pp;

			if (k == 0) begin : g_first
				assign a_src  = a;
				assign b_src  = b_ext;
				assign acc_in = '0;
			end else begin : g_next
				assign a_src  = a_s[k-1];
				assign b_src  = b_s[k-1];
				assign acc_in = acc_s[k-1];
			end

			// top limb carries the sign, lower limbs are unsigned
			assign limb = b_src[k*LIMB +: LIMB];
			if (k == NL - 1) begin : g_top
				assign limb_x = $signed({limb[LIMB-1], limb});
			end else begin : g_low
				assign limb_x = $signed({1'b0, limb});
			end

			assign prod = PRW'($signed(a_src)) * PRW'(limb_x);
			assign pp   = P_BITS'(prod) << (k * LIMB);

			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[k] <= acc_in + pp;
				end
			end

			if (k < NL - 1) begin : g_fwd
				always_ff @(posedge clk) begin
					if (en) begin
						a_s[k] <= a_src;
						b_s[k] <= b_src;
					end
				end
			end
		end
	endgenerate

	assign p = $signed(acc_s[NL-1]);

endmodule

// ----- design/lpcp_dly.sv -----
// ----------------------------------------------------------------------------
// lpcp_dly
// Stallable delay line for side data that rides next to the arithmetic,
// with a valid bit per stage.
// ----------------------------------------------------------------------------
module lpcp_dly #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	output logic [WIDTH-1:0] out_data
);

	logic             vld_s [DEPTH];
	logic [WIDTH-1:0] dat_s [DEPTH];

	genvar k;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_tap
			logic             v_in;
			logic [WIDTH-1:0] d_in;

			if (k == 0) begin : g_first
				assign v_in = in_valid;
				assign d_in = in_data;
			end else begin : g_next
				assign v_in = vld_s[k-1];
				assign d_in = dat_s[k-1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dat_s[k] <= d_in;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[DEPTH-1];
	assign out_data  = dat_s[DEPTH-1];

endmodule

// ----- design/lpcp_div.sv -----
// ----------------------------------------------------------------------------
// lpcp_div
// Pipelined rounded division plus offset: foot = sat(base + round(num/den)).
// One quotient bit per stage; quotients too wide for the COORD_BITS + 2 kept
// bits are flagged up front and saturate, as do sums beyond the coordinate range.
// ----------------------------------------------------------------------------
module lpcp_div #(
	parameter int COORD_BITS = 32,
	parameter int NUM_BITS   = 169,
	parameter int DEN_BITS   = 136
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [NUM_BITS-1:0]   num,
	input  logic        [DEN_BITS-1:0]   den,
	input  logic signed [COORD_BITS-1:0] base,
	output logic signed [COORD_BITS-1:0] foot
);

	localparam int C  = COORD_BITS;
	localparam int QB = C + 2;          // quotient bits kept
	localparam int RW = DEN_BITS + QB;  // remainder width
	localparam int SW = QB + 3;         // width of base + signed quotient

	// stage 1: magnitude of the numerator
	logic                neg_s1;
	logic [NUM_BITS-1:0] mag_s1;
	logic [DEN_BITS-1:0] den_s1;
	logic [C-1:0]        base_s1;
	logic [NUM_BITS-1:0] num_u;

	assign num_u = num;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= num_u[NUM_BITS-1];
			mag_s1  <= num_u[NUM_BITS-1] ? (~num_u + 1'b1) : num_u;
			den_s1  <= den;
			base_s1 <= base;
		end
	end

	// quotient chain, index 0 is the overflow check stage
	logic [RW-1:0]       r_s    [QB+1];
	logic [QB-1:0]       q_s    [QB+1];
	logic [DEN_BITS-1:0] den_s  [QB+1];
	logic                neg_s  [QB+1];
	logic                ovf_s  [QB+1];
	logic [C-1:0]        base_s [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= RW'(mag_s1);
			q_s[0]    <= '0;
			den_s[0]  <= den_s1;
			neg_s[0]  <= neg_s1;
			ovf_s[0]  <= RW'(mag_s1) >= {den_s1, {QB{1'b0}}};
			base_s[0] <= base_s1;
		end
	end

	genvar i;
	generate
		for (i = 0; i < QB; i++) begin : g_bit
			localparam int K = QB - 1 - i;
			logic [RW-1:0] trial;
			logic          ge;
			logic [QB-1:0] q_nx;

			assign trial = RW'(den_s[i]) << K;
			assign ge    = r_s[i] >= trial;

			always_comb begin
				q_nx    = q_s[i];
				q_nx[K] = ge;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[i+1]    <= ge ? (r_s[i] - trial) : r_s[i];
					q_s[i+1]    <= q_nx;
					den_s[i+1]  <= den_s[i];
					neg_s[i+1]  <= neg_s[i];
					ovf_s[i+1]  <= ovf_s[i];
					base_s[i+1] <= base_s[i];
				end
			end
		end
	endgenerate

	// round half away from zero: bump when 2r >= den
	logic          rnd;
	logic [QB:0]   qr_s3;
	logic          neg_s3;
	logic          ovf_s3;
	logic [C-1:0]  base_s3;

	assign rnd = {r_s[QB][DEN_BITS-1:0], 1'b0} >= {1'b0, den_s[QB]};

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s3   <= (QB+1)'(q_s[QB]) + (QB+1)'(rnd);
			neg_s3  <= neg_s[QB];
			ovf_s3  <= ovf_s[QB];
			base_s3 <= base_s[QB];
		end
	end

	// apply sign, add base point, saturate
	logic signed [QB+1:0] val;
	logic signed [SW-1:0] sum;
	logic [C-1:0]         res;
	logic [C-1:0]         max_v;
	logic [C-1:0]         min_v;
	logic [C-1:0]         foot_s4;

	assign max_v = {1'b0, {(C-1){1'b1}}};
	assign min_v = {1'b1, {(C-1){1'b0}}};
	assign val   = neg_s3 ? -$signed({1'b0, qr_s3}) : $signed({1'b0, qr_s3});
	assign sum   = SW'($signed(base_s3)) + SW'(val);

	always_comb begin
		priority if (ovf_s3) begin
			res = neg_s3 ? min_v : max_v;
		end else if ((&sum[SW-1:C-1]) || !(|sum[SW-1:C-1])) begin
			res = sum[C-1:0];
		end else begin
			res = sum[SW-1] ? min_v : max_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			foot_s4 <= res;
		end
	end

	assign foot = $signed(foot_s4);

endmodule

// ----- design/line_pair_common_perpendicular_core.sv -----
// ----------------------------------------------------------------------------
// line_pair_common_perpendicular_core
// Feet of the common perpendicular of two 3D lines in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one line pair per clock and returns one result per request, in order.
// Each line is given by two endpoints; the core returns foot P on line A and
// foot Q on line B, rounded to the nearest LSB (ties away from zero) and
// saturated, plus a status: solved, shared endpoint (both feet are that
// point) or no unique perpendicular (parallel or degenerate, feet zero).
// Coordinates may use any fraction split (e.g. Q16.16); the math is scale
// free. The datapath is a fixed pipeline: input register, cross products,
// dot products, numerator products, then a one-bit-per-stage divider.
// Throughput is one pair per cycle; backpressure stalls the whole pipeline once
// the two-entry output buffer is full.
// ----------------------------------------------------------------------------
module line_pair_common_perpendicular_core
	import lpcp_pkg::*;
#(
	parameter int COORD_BITS = 32,
	localparam int IN_W  = ((12 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((6 * COORD_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// line_a_start_x/y/z, line_a_end_x/y/z, line_b_start_x/y/z, line_b_end_x/y/z
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// foot_a_x/y/z, foot_b_x/y/z
	output logic [OUT_W-1:0] m_axis_tdata,
	// result_status
	output logic [1:0]       m_axis_tuser
);

	localparam int C    = COORD_BITS;
	localparam int W    = C + 1;
	localparam int NW   = 2 * W + 1;
	localparam int DW   = 2 * NW + 2;
	localparam int NUMW = W + DW;
	localparam int L1   = (W + LIMB - 1) / LIMB;
	localparam int L2   = (NW + LIMB - 1) / LIMB;
	localparam int L3   = (DW + LIMB - 1) / LIMB;
	localparam int LD   = C + 6;
	localparam int SA_W = 1 + 9 * C + 6 * W;
	localparam int SB_W = 2 + 9 * C + DW;
	localparam int SC_W = 2 + 3 * C;

	logic en;
	logic skid_valid_q;

	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	// ------------------------------------------------------------------
	// Stage 1: differences and shared endpoint detection
	// ------------------------------------------------------------------
	logic [2:0][C-1:0] pa0, pa1, pb0, pb1;
	logic              sh_hit;
	logic [2:0][C-1:0] sh_pt;

	assign pa0 = s_axis_tdata[0     +: 3*C];
	assign pa1 = s_axis_tdata[3*C   +: 3*C];
	assign pb0 = s_axis_tdata[6*C   +: 3*C];
	assign pb1 = s_axis_tdata[9*C   +: 3*C];

	always_comb begin
		sh_hit = 1'b1;
		sh_pt  = pa0;
		priority if (pa0 == pb0) begin
			sh_pt = pa0;
		end else if (pa0 == pb1) begin
			sh_pt = pa0;
		end else if (pa1 == pb0) begin
			sh_pt = pa1;
		end else if (pa1 == pb1) begin
			sh_pt = pa1;
		end else begin
			sh_hit = 1'b0;
		end
	end

	logic              valid_s1;
	logic [2:0][W-1:0] u_s1, v_s1, d_s1;
	logic [2:0][C-1:0] a0_s1, b0_s1, shpt_s1;
	logic              sh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				u_s1[j] <= $signed({pa1[j][C-1], pa1[j]}) - $signed({pa0[j][C-1], pa0[j]});
				v_s1[j] <= $signed({pb1[j][C-1], pb1[j]}) - $signed({pb0[j][C-1], pb0[j]});
				d_s1[j] <= $signed({pb0[j][C-1], pb0[j]}) - $signed({pa0[j][C-1], pa0[j]});
			end
			a0_s1   <= pa0;
			b0_s1   <= pb0;
			shpt_s1 <= sh_pt;
			sh_s1   <= sh_hit;
		end
	end

	// ------------------------------------------------------------------
	// Cross products n = u x v, dv = d x v, du = d x u
	// ------------------------------------------------------------------
	logic [2:0][2:0][W-1:0] xl, xr;
	logic signed [2*W-1:0]  pr1 [3][3][2];

	always_comb begin
		xl[0] = u_s1; xr[0] = v_s1;
		xl[1] = d_s1; xr[1] = v_s1;
		xl[2] = d_s1; xr[2] = u_s1;
	end

	genvar c, j;
	generate
		for (c = 0; c < 3; c++) begin : g_x
			for (j = 0; j < 3; j++) begin : g_xc
				lpcp_mul #(.A_BITS(W), .B_BITS(W)) u_mul_p (
					.clk (clk),
					.en  (en),
					.a   ($signed(xl[c][(j+1)%3])),
					.b   ($signed(xr[c][(j+2)%3])),
					.p   (pr1[c][j][0])
				);
				lpcp_mul #(.A_BITS(W), .B_BITS(W)) u_mul_m (
					.clk (clk),
					.en  (en),
					.a   ($signed(xl[c][(j+2)%3])),
					.b   ($signed(xr[c][(j+1)%3])),
					.p   (pr1[c][j][1])
				);
			end
		end
	endgenerate

	logic [2:0][2:0][NW-1:0] cr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					cr_s2[a][b] <= NW'(pr1[a][b][0]) - NW'(pr1[a][b][1]);
				end
			end
		end
	end

	// side data up to stage 2
	logic              valid_2, sh_2;
	logic [2:0][C-1:0] shpt_2, a0_2, b0_2;
	logic [2:0][W-1:0] u_2, v_2;

	lpcp_dly #(.WIDTH(SA_W), .DEPTH(L1 + 1)) u_dly_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.in_data   ({sh_s1, shpt_s1, a0_s1, b0_s1, u_s1, v_s1}),
		.out_valid (valid_2),
		.out_data  ({sh_2, shpt_2, a0_2, b0_2, u_2, v_2})
	);

	// ------------------------------------------------------------------
	// Dot products |n|^2, dv.n, du.n
	// ------------------------------------------------------------------
	logic signed [2*NW-1:0] pr2 [3][3];

	generate
		for (c = 0; c < 3; c++) begin : g_d
			for (j = 0; j < 3; j++) begin : g_dc
				lpcp_mul #(.A_BITS(NW), .B_BITS(NW)) u_mul (
					.clk (clk),
					.en  (en),
					.a   ($signed(cr_s2[c][j])),
					.b   ($signed(cr_s2[0][j])),
					.p   (pr2[c][j])
				);
			end
		end
	endgenerate

	logic [2:0][DW-1:0] dot_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				dot_s3[a] <= DW'(pr2[a][0]) + DW'(pr2[a][1]) + DW'(pr2[a][2]);
			end
		end
	end

	logic              valid_3, sh_3;
	logic [2:0][C-1:0] shpt_3, a0_3, b0_3;
	logic [2:0][W-1:0] u_3, v_3;

	lpcp_dly #(.WIDTH(SA_W), .DEPTH(L2 + 1)) u_dly_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_2),
		.in_data   ({sh_2, shpt_2, a0_2, b0_2, u_2, v_2}),
		.out_valid (valid_3),
		.out_data  ({sh_3, shpt_3, a0_3, b0_3, u_3, v_3})
	);

	// ------------------------------------------------------------------
	// Numerators u*s and v*t
	// ------------------------------------------------------------------
	logic signed [NUMW-1:0] num_a [3];
	logic signed [NUMW-1:0] num_b [3];
	logic                   degen_3;

	assign degen_3 = (dot_s3[0] == '0);

	generate
		for (j = 0; j < 3; j++) begin : g_n
			lpcp_mul #(.A_BITS(W), .B_BITS(DW)) u_mul_a (
				.clk (clk),
				.en  (en),
				.a   ($signed(u_3[j])),
				.b   ($signed(dot_s3[1])),
				.p   (num_a[j])
			);
			lpcp_mul #(.A_BITS(W), .B_BITS(DW)) u_mul_b (
				.clk (clk),
				.en  (en),
				.a   ($signed(v_3[j])),
				.b   ($signed(dot_s3[2])),
				.p   (num_b[j])
			);
		end
	endgenerate

	logic              valid_4, sh_4, degen_4;
	logic [2:0][C-1:0] shpt_4, a0_4, b0_4;
	logic [DW-1:0]     den_4;

	lpcp_dly #(.WIDTH(SB_W), .DEPTH(L3)) u_dly_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_3),
		.in_data   ({sh_3, degen_3, shpt_3, a0_3, b0_3, dot_s3[0]}),
		.out_valid (valid_4),
		.out_data  ({sh_4, degen_4, shpt_4, a0_4, b0_4, den_4})
	);

	// ------------------------------------------------------------------
	// Division, rounding, offset and saturation per coordinate
	// ------------------------------------------------------------------
	logic signed [C-1:0] foot [6];

	generate
		for (j = 0; j < 3; j++) begin : g_q
			lpcp_div #(.COORD_BITS(C), .NUM_BITS(NUMW), .DEN_BITS(DW)) u_div_a (
				.clk  (clk),
				.en   (en),
				.num  (num_a[j]),
				.den  (den_4),
				.base ($signed(a0_4[j])),
				.foot (foot[j])
			);
			lpcp_div #(.COORD_BITS(C), .NUM_BITS(NUMW), .DEN_BITS(DW)) u_div_b (
				.clk  (clk),
				.en   (en),
				.num  (num_b[j]),
				.den  (den_4),
				.base ($signed(b0_4[j])),
				.foot (foot[3+j])
			);
		end
	endgenerate

	logic              valid_5, sh_5, degen_5;
	logic [2:0][C-1:0] shpt_5;

	lpcp_dly #(.WIDTH(SC_W), .DEPTH(LD)) u_dly_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_4),
		.in_data   ({sh_4, degen_4, shpt_4}),
		.out_valid (valid_5),
		.out_data  ({sh_5, degen_5, shpt_5})
	);

	// result select by status
	logic [5:0][C-1:0] res_feet;
	stat_t             res_stat;

	always_comb begin
		priority if (sh_5) begin
			res_stat = STAT_SHARED;
			res_feet = {shpt_5, shpt_5};
		end else if (degen_5) begin
			res_stat = STAT_NONE;
			res_feet = '0;
		end else begin
			res_stat = STAT_SOLVED;
			for (int k = 0; k < 6; k++) begin
				res_feet[k] = foot[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register with skid entry
	// ------------------------------------------------------------------
	logic              out_valid_q;
	logic [5:0][C-1:0] out_feet_q, skid_feet_q;
	stat_t             out_stat_q, skid_stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= valid_5;
			end
		end else if (valid_5 && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_feet_q <= skid_feet_q;
				out_stat_q <= skid_stat_q;
			end else begin
				out_feet_q <= res_feet;
				out_stat_q <= res_stat;
			end
		end else if (!skid_valid_q) begin
			skid_feet_q <= res_feet;
			skid_stat_q <= res_stat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_feet_q);
	assign m_axis_tuser  = out_stat_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_skid_behind_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid entry filled without output stall");

	a_no_drop : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> out_valid_q)
		else $error("pending result dropped");

	a_none_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stat_q == STAT_NONE) |-> (out_feet_q == '0))
		else $error("no-solution result carries nonzero feet");

endmodule

// ----- tb/sv/line_pair_common_perpendicular_core_test.sv -----
// ----------------------------------------------------------------------------
// line_pair_common_perpendicular_core_test
// Self-checking bench for the common perpendicular core.
// ----------------------------------------------------------------------------
// Streams line pairs into the core and predicts each result with exact wide
// integer arithmetic. The stimulus is a short directed set followed by random
// pairs of several kinds: skew, full range, shared endpoint, parallel and
// degenerate. Both sides idle at random. The receiver also holds off once for
// a long stretch, and the sender once drains the pipe.
// ----------------------------------------------------------------------------
module line_pair_common_perpendicular_core_test
	import lpcp_pkg::*;
();

	localparam int CW        = 32;
	localparam int IN_W      = 12 * CW;
	localparam int OUT_W     = 6 * CW;
	localparam int N_RANDOM  = 1400;
	localparam int TAIL      = 200;
	localparam int LIMIT     = 2000000;
	localparam int HOLD_LEN  = 600;

	typedef logic signed [255:0] wide_t;
	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		logic [OUT_W-1:0] feet;
		stat_t            status;
	} feet_t;

	// Expected feet of each accepted pair, oldest first
	class foot_scoreboard;
		feet_t pending_feet[$];

		function automatic wide_t round_div(wide_t num, wide_t den);
			logic  neg;
			wide_t mag;
			wide_t quo;
			wide_t rem;
			neg = num < 0;
			mag = neg ? -num : num;
			quo = mag / den;
			rem = mag % den;
			// ties away from zero
			if (rem >= den - rem)
				quo = quo + 1;
			return neg ? -quo : quo;
		endfunction

		function automatic coord_t clamp(wide_t x);
			wide_t hi;
			wide_t lo;
			hi = (wide_t'(1) <<< (CW - 1)) - 1;
			lo = -hi - 1;
			if (x > hi)
				return coord_t'(hi);
			if (x < lo)
				return coord_t'(lo);
			return coord_t'(x);
		endfunction

		function automatic void note_pair(logic [IN_W-1:0] data);
			wide_t pt[4][3];
			wide_t u[3];
			wide_t v[3];
			wide_t d[3];
			wide_t n[3];
			wide_t dv[3];
			wide_t du[3];
			wide_t den;
			wide_t s;
			wide_t t;
			feet_t exp_f;
			int    ends[4][2];
			int    a;
			int    b;
			ends = '{'{0, 2}, '{0, 3}, '{1, 2}, '{1, 3}};
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 3; j++)
					pt[i][j] = wide_t'(coord_t'(data[CW*(3*i+j) +: CW]));
			// shared endpoint wins over the parallel test
			for (int k = 0; k < 4; k++) begin
				a = ends[k][0];
				b = ends[k][1];
				if (pt[a][0] == pt[b][0] && pt[a][1] == pt[b][1] && pt[a][2] == pt[b][2]) begin
					for (int j = 0; j < 3; j++) begin
						exp_f.feet[CW*j +: CW]     = coord_t'(pt[a][j]);
						exp_f.feet[CW*(3+j) +: CW] = coord_t'(pt[a][j]);
					end
					exp_f.status = STAT_SHARED;
					pending_feet.push_back(exp_f);
					return;
				end
			end
			for (int j = 0; j < 3; j++) begin
				u[j] = pt[1][j] - pt[0][j];
				v[j] = pt[3][j] - pt[2][j];
				d[j] = pt[2][j] - pt[0][j];
			end
			n[0] = u[1] * v[2] - u[2] * v[1];
			n[1] = u[2] * v[0] - u[0] * v[2];
			n[2] = u[0] * v[1] - u[1] * v[0];
			den = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
			if (den == 0) begin
				exp_f.feet   = '0;
				exp_f.status = STAT_NONE;
				pending_feet.push_back(exp_f);
				return;
			end
			dv[0] = d[1] * v[2] - d[2] * v[1];
			dv[1] = d[2] * v[0] - d[0] * v[2];
			dv[2] = d[0] * v[1] - d[1] * v[0];
			du[0] = d[1] * u[2] - d[2] * u[1];
			du[1] = d[2] * u[0] - d[0] * u[2];
			du[2] = d[0] * u[1] - d[1] * u[0];
			s = dv[0] * n[0] + dv[1] * n[1] + dv[2] * n[2];
			t = du[0] * n[0] + du[1] * n[1] + du[2] * n[2];
			for (int j = 0; j < 3; j++) begin
				exp_f.feet[CW*j +: CW]     = clamp(pt[0][j] + round_div(u[j] * s, den));
				exp_f.feet[CW*(3+j) +: CW] = clamp(pt[2][j] + round_div(v[j] * t, den));
			end
			exp_f.status = STAT_SOLVED;
			pending_feet.push_back(exp_f);
		endfunction

		// returns an empty string on a match
		function automatic string check_feet(logic [OUT_W-1:0] feet, logic [1:0] status);
			feet_t exp_f;
			string msg;
			if (pending_feet.size() == 0)
				return "result with no pair outstanding";
			exp_f = pending_feet.pop_front();
			msg = "";
			for (int j = 0; j < 6; j++)
				if (feet[CW*j +: CW] !== exp_f.feet[CW*j +: CW])
					msg = {msg, $sformatf(" foot%0d got %h exp %h", j,
						feet[CW*j +: CW], exp_f.feet[CW*j +: CW])};
			if (status !== exp_f.status)
				msg = {msg, $sformatf(" status got %0d exp %0d", status, exp_f.status)};
			return msg;
		endfunction

		function automatic int outstanding();
			return pending_feet.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [1:0]       m_axis_tuser;

	foot_scoreboard sb;
	int             mismatches;
	int             cycles;
	bit             hold_go;
	int             hold_cnt;
	int             stall_cnt;

	line_pair_common_perpendicular_core #(.COORD_BITS(CW)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(string msg);
		$display("mismatch at cycle %0d:%s", cycles, msg);
		mismatches++;
	endtask

	// Watch both handshakes
	always @(posedge clk) begin
		string msg;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_pair(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			msg = sb.check_feet(m_axis_tdata, m_axis_tuser);
			if (msg != "")
				report(msg);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_go) begin
			hold_go  = 1'b0;
			hold_cnt = HOLD_LEN;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			stall_cnt = ($urandom_range(3) == 0) ? pick_gap() : 0;
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_pair(logic [IN_W-1:0] data, int gap);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [IN_W-1:0] pack_pair(coord_t c[12]);
		logic [IN_W-1:0] data;
		for (int i = 0; i < 12; i++)
			data[CW*i +: CW] = c[i];
		return data;
	endfunction

	function automatic coord_t rand_coord(int kind);
		unique case (kind)
			0:       return coord_t'($signed($urandom_range(2097151)) - 1048576);
			1:       return coord_t'($urandom);
			default: return coord_t'($signed($urandom_range(63)) - 32);
		endcase
	endfunction

	// Random pair: mostly skew lines, some with special structure
	function automatic logic [IN_W-1:0] random_pair();
		coord_t c[12];
		int     mode;
		int     kind;
		int     src;
		int     dst;
		int     k;
		mode = $urandom_range(99);
		kind = $urandom_range(2);
		for (int i = 0; i < 12; i++)
			c[i] = rand_coord(kind);
		if (mode < 10) begin
			// shared endpoint
			src = $urandom_range(1);
			dst = $urandom_range(3, 2);
			for (int j = 0; j < 3; j++)
				c[3*dst+j] = c[3*src+j];
		end else if (mode < 17) begin
			// parallel: v = k * u
			k = $signed($urandom_range(6)) - 3;
			for (int j = 0; j < 3; j++) begin
				c[j]   = rand_coord(0);
				c[3+j] = c[j] + rand_coord(2);
				c[9+j] = c[6+j] + k * (c[3+j] - c[j]);
			end
		end else if (mode < 22) begin
			// degenerate line
			for (int j = 0; j < 3; j++)
				c[9+j] = c[6+j];
		end
		return pack_pair(c);
	endfunction

	task automatic run_directed();
		coord_t c[12];
		coord_t mx;
		coord_t mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		// all zero: shared endpoint
		c = '{default: 0};
		send_pair(pack_pair(c), 0);
		// shared endpoint in each of the four pair positions
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 12; i++)
				c[i] = coord_t'(i * 65536 + 1);
			for (int j = 0; j < 3; j++)
				c[3*(2 + k % 2) + j] = c[3*(k / 2) + j];
			send_pair(pack_pair(c), 0);
		end
		// perpendicular skew unit lines
		c = '{0, 0, 0, 65536, 0, 0, 0, 65536, 65536, 0, 65536, 131072};
		send_pair(pack_pair(c), 0);
		// parallel lines
		c = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0, 131072, 65536, 0};
		send_pair(pack_pair(c), 1);
		// degenerate first line
		c = '{5, 6, 7, 5, 6, 7, 0, 65536, 0, 1, 2, 3};
		send_pair(pack_pair(c), 0);
		// extreme coordinates
		c = '{mn, mn, mn, mx, mx, mx, mx, mn, mn, mn, mx, mx};
		send_pair(pack_pair(c), 0);
		c = '{mx, mn, mx, mn, mx, mn, mn, mn, mx, mx, mx, mn};
		send_pair(pack_pair(c), 0);
		c = '{mx, mx, mx, mn, mn, mn, mx, mx, mn, mn, mn, mx};
		send_pair(pack_pair(c), 0);
		// far feet beyond both ends of the range
		c = '{0, 0, 0, 1, 0, 0, mx - 1000, 2, 5, mx, 1, 5};
		send_pair(pack_pair(c), 0);
		c = '{0, 0, 0, 1, 0, 0, mn + 1000, 2, 5, mn, 1, 5};
		send_pair(pack_pair(c), 2);
		c = '{0, 0, 0, 0, 0, 1, 3, 7, mx - 10, 3, 8, mx};
		send_pair(pack_pair(c), 0);
		// tiny directions near rounding ties
		c = '{0, 0, 0, 2, 0, 0, 1, 1, 1, 1, 1, 2};
		send_pair(pack_pair(c), 0);
		c = '{0, 0, 0, 3, 1, 0, -1, 0, 1, 0, -1, 2};
		send_pair(pack_pair(c), 0);
	endtask

	initial begin
		sb            = new();
		mismatches    = 0;
		cycles        = 0;
		hold_go       = 1'b0;
		hold_cnt      = 0;
		stall_cnt     = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		for (int i = 0; i < N_RANDOM; i++) begin
			// long receiver hold-off while the sender keeps offering
			if (i == 200)
				hold_go = 1'b1;
			// drain the pipe once before carrying on
			if (i == 700) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				while (sb.outstanding() != 0)
					@(posedge clk);
			end
			send_pair(random_pair(), (i >= 200 && i < 300) ? 0 : pick_gap());
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && sb.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/lpcp_pkg.sv
design/lpcp_mul.sv
design/lpcp_dly.sv
design/lpcp_div.sv
design/line_pair_common_perpendicular_core.sv
tb/sv/line_pair_common_perpendicular_core_test.sv
